[sv/vsa_pkg.sv]
// ----------------------------------------------------------------------------
// Voice slot allocator package
// Sizes, codes and shared types of the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

	localparam int NUM_SLOTS     = 12;
	localparam int MAX_INSTANCES = 128;
	localparam int NUM_SOUNDS    = 128;

	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int PAN_DEPTH = NUM_SLOTS * MAX_INSTANCES;
	localparam int PAN_AW    = (PAN_DEPTH > 1) ? $clog2(PAN_DEPTH) : 1;
	localparam int SND_AW    = $clog2(NUM_SOUNDS);

	localparam int SID_W  = 7;
	localparam int BUF_W  = 16;
	localparam int XOFF_W = 13;
	localparam int INST_W = 7;
	localparam int PAN_W  = 11;
	localparam int SLOT_OUT_W = 4;

	typedef enum logic [1:0] {
		ST_CLAIMED    = 2'd0,
		ST_ADDED      = 2'd1,
		ST_NO_SLOT    = 2'd2,
		ST_POLY_LIMIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [7:0] sound;
		logic [7:0] count;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} slot_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       data;
	} slot_wr_t;

	typedef struct packed {
		logic                    pan_en;
		logic [PAN_AW-1:0]       pan_addr;
		logic signed [PAN_W-1:0] pan_data;
		logic                    buf_en;
		logic [SND_AW-1:0]       buf_addr;
		logic signed [BUF_W-1:0] buf_data;
	} wave_wr_t;

endpackage

[sv/sound_voice_slot_allocator_core.sv]
// ----------------------------------------------------------------------------
// Sound voice slot allocator core
// Assigns play requests to voice slots under a per-slot polyphony limit.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance the slot table memory is
// read one slot per cycle, pipelined against the compare, through the slots
// already in use, up to and including a match, so 0 to 12 slots are read. A
// decided result waits while an output stall holds the previous result, and
// the next request is taken in the cycle after the result is loaded. Slots
// fill in order and are never freed, so a fill count marks the occupied ones
// and no clearing pass is needed after reset.
// The result waits in an output register; a new request is taken once the
// previous result is loaded there.
module sound_voice_slot_allocator_core
	import vsa_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SID_W-1:0]           sound_id,
	input  logic signed [BUF_W-1:0]    buffer_index,
	input  logic signed [XOFF_W-1:0]   x_offset,
	output logic                       out_valid,
	input  logic                       out_stall,
	output status_t                    status,
	output logic [SLOT_OUT_W-1:0]      slot_index,
	output logic [INST_W-1:0]          instance_index,
	output logic signed [PAN_W-1:0]    pan_value
);

	state_t                  state_q, state_d;
	logic [SID_W-1:0]        sid_q;
	logic signed [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic [CNT_W-1:0]        used_q;
	logic                    cmp_vld_s1;
	logic [SLOT_W-1:0]       cmp_idx_s1;
	status_t                 res_status_q;
	logic [SLOT_W-1:0]       res_slot_q;
	logic [7:0]              res_inst_q;
	logic [7:0]              res_cnt_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [SLOT_OUT_W-1:0]   out_slot_q;
	logic [INST_W-1:0]       out_inst_q;
	logic signed [PAN_W-1:0] out_pan_q;

	logic                    accept;
	logic                    hit;
	logic                    at_end;
	logic                    full;
	logic                    dec_en;
	status_t                 dec_status;
	logic [SLOT_W-1:0]       dec_slot;
	logic [7:0]              dec_inst;
	logic [7:0]              dec_cnt;
	logic                    out_load;
	logic                    granted;
	logic signed [PAN_W-1:0] pan;
	slot_rd_t                slot_rd;
	slot_wr_t                slot_wr;
	slot_entry_t             slot_rdata;
	wave_wr_t                wave_wr;

	vsa_pan u_pan (
		.clk      (clk),
		.load     (accept),
		.x_offset (x_offset),
		.pan      (pan)
	);

	vsa_slot_ram u_slot_ram (
		.clk   (clk),
		.rd    (slot_rd),
		.wr    (slot_wr),
		.rdata (slot_rdata)
	);

	vsa_wave_store u_wave_store (
		.clk (clk),
		.wr  (wave_wr)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign hit      = cmp_vld_s1 && (slot_rdata.sound == {1'b0, sid_q});
	assign at_end   = (rd_idx_q == used_q);
	assign full     = (used_q == CNT_W'(NUM_SLOTS));
	assign granted  = (res_status_q == ST_CLAIMED) || (res_status_q == ST_ADDED);

	always_comb begin
		state_d    = state_q;
		slot_rd.en   = 1'b0;
		slot_rd.addr = rd_idx_q[SLOT_W-1:0];
		dec_en     = 1'b0;
		dec_status = ST_NO_SLOT;
		dec_slot   = '0;
		dec_inst   = '0;
		dec_cnt    = '0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					dec_en  = 1'b1;
					state_d = S_FINISH;
					if (slot_rdata.count >= 8'(MAX_INSTANCES)) begin
						dec_status = ST_POLY_LIMIT;
					end else begin
						dec_status = ST_ADDED;
						dec_slot   = cmp_idx_s1;
						dec_inst   = slot_rdata.count;
						dec_cnt    = slot_rdata.count + 8'd1;
					end
				end else if (at_end) begin
					dec_en  = 1'b1;
					state_d = S_FINISH;
					if (!full) begin
						dec_status = ST_CLAIMED;
						dec_slot   = rd_idx_q[SLOT_W-1:0];
						dec_cnt    = 8'd1;
					end
				end else begin
					slot_rd.en = 1'b1;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		slot_wr.en         = out_load && granted;
		slot_wr.addr       = res_slot_q;
		slot_wr.data.sound = {1'b0, sid_q};
		slot_wr.data.count = res_cnt_q;
		wave_wr.pan_en     = out_load && granted;
		wave_wr.pan_addr   = PAN_AW'(PAN_AW'(res_slot_q) * PAN_AW'(MAX_INSTANCES)
			+ PAN_AW'(res_inst_q));
		wave_wr.pan_data   = pan;
		wave_wr.buf_en     = out_load && (res_status_q == ST_CLAIMED)
			&& ({1'b0, sid_q} < (SID_W + 1)'(NUM_SOUNDS));
		wave_wr.buf_addr   = SND_AW'(sid_q);
		wave_wr.buf_data   = buf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (slot_rd.en) begin
				rd_idx_q   <= rd_idx_q + CNT_W'(1);
				cmp_vld_s1 <= 1'b1;
			end else if (dec_en) begin
				cmp_vld_s1 <= 1'b0;
			end
			if (out_load && (res_status_q == ST_CLAIMED)) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sid_q <= sound_id;
			buf_q <= buffer_index;
		end
		if (slot_rd.en) begin
			cmp_idx_s1 <= rd_idx_q[SLOT_W-1:0];
		end
		if (dec_en) begin
			res_status_q <= dec_status;
			res_slot_q   <= dec_slot;
			res_inst_q   <= dec_inst;
			res_cnt_q    <= dec_cnt;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= SLOT_OUT_W'(res_slot_q);
			out_inst_q   <= res_inst_q[INST_W-1:0];
			out_pan_q    <= pan;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign slot_index     = out_slot_q;
	assign instance_index = out_inst_q;
	assign pan_value      = out_pan_q;

endmodule

[sv/vsa_pan.sv]
// ----------------------------------------------------------------------------
// Pan converter
// Turns a horizontal offset into a saturated pan, offset*1000/3072 toward zero.
// ----------------------------------------------------------------------------
module vsa_pan
	import vsa_pkg::*;
(
	input  logic                     clk,
	input  logic                     load,
	input  logic signed [XOFF_W-1:0] x_offset,
	output logic signed [PAN_W-1:0]  pan
);

	localparam int PROD_W  = 22;
	localparam int KILO_W  = 12;
	localparam int RECIP_W = 16;
	localparam int THIRD_W = KILO_W + RECIP_W;
	localparam logic [9:0]         PanScale = 10'd1000;
	localparam logic [RECIP_W-1:0] Recip3   = 16'd43691;
	localparam logic [PAN_W-1:0]   PanLimit = 11'd1000;

	logic [XOFF_W-1:0]  mag;
	logic [PROD_W-1:0]  prod_s1;
	logic               neg_s1;
	logic [THIRD_W-1:0] third_s2;
	logic               neg_s2;
	logic [PAN_W-1:0]   quot;
	logic [PAN_W-1:0]   sat;

	assign mag = x_offset[XOFF_W-1] ? XOFF_W'(-x_offset) : XOFF_W'(x_offset);

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(PanScale);
			neg_s1  <= x_offset[XOFF_W-1];
		end
		third_s2 <= THIRD_W'(prod_s1[PROD_W-1:10]) * THIRD_W'(Recip3);
		neg_s2   <= neg_s1;
	end

	assign quot = third_s2[THIRD_W-1:17];
	assign sat  = (quot > PanLimit) ? PanLimit : quot;
	assign pan  = neg_s2 ? PAN_W'(-sat) : PAN_W'(sat);

endmodule

[sv/vsa_slot_ram.sv]
// ----------------------------------------------------------------------------
// Slot table memory
// Sound id and instance count per slot, with a registered (synchronous) read.
// ----------------------------------------------------------------------------
module vsa_slot_ram
	import vsa_pkg::*;
(
	input  logic        clk,
	input  slot_rd_t    rd,
	input  slot_wr_t    wr,
	output slot_entry_t rdata
);

	slot_entry_t mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

[sv/vsa_wave_store.sv]
// ----------------------------------------------------------------------------
// Wave store
// Pan of every instance and buffer index of every sound, for the mixer side.
// ----------------------------------------------------------------------------
module vsa_wave_store
	import vsa_pkg::*;
(
	input  logic     clk,
	input  wave_wr_t wr
);

	logic signed [PAN_W-1:0] pan_mem [PAN_DEPTH];
	logic signed [BUF_W-1:0] buf_mem [NUM_SOUNDS];

	always_ff @(posedge clk) begin
		if (wr.pan_en) begin
			pan_mem[wr.pan_addr] <= wr.pan_data;
		end
		if (wr.buf_en) begin
			buf_mem[wr.buf_addr] <= wr.buf_data;
		end
	end

endmodule
